>>> hw/rtl/mla_pkg.sv
// mla_pkg: constants, width helpers and the result record of the line assembler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mla_pkg;

  localparam int DEF_SLOTS      = 4;
  localparam int DEF_LINE_BYTES = 32;
  localparam int CMD_QDEPTH     = 4;
  localparam int OUT_QDEPTH     = 4;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] line_byte;
    logic [1:0] slot_index;
    logic [7:0] line_channel;
    logic       last;
  } out_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int cnt_w(input int n);
    return $clog2(n + 1);
  endfunction

  function automatic int tmo_w(input int slots);
    return $clog2(4 * slots + 4);
  endfunction

endpackage

>>> hw/rtl/mla_fifo.sv
// mla_fifo: small synchronous queue with occupancy count
// depends on mla_pkg for width helpers
`timescale 1ns / 1ps

module mla_fifo
  import mla_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [WIDTH-1:0]          din,
  input  logic                      pop,
  output logic [WIDTH-1:0]          dout,
  output logic                      full,
  output logic                      empty,
  output logic [cnt_w(DEPTH)-1:0]   count
);

  localparam int PW = idx_w(DEPTH);
  localparam int CW = cnt_w(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/mla_front.sv
// mla_front: takes input beats, ages and binds slots, tracks fill offsets
// depends on mla_pkg; issues store and line commands into the command queue
`timescale 1ns / 1ps

module mla_front
  import mla_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int CMD_W      = 1 + idx_w(SLOTS) + $clog2(LINE_BYTES) + 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       channel,
  input  logic [7:0]       data,
  input  logic             frame_start,
  input  logic             byte_present,
  input  logic             push,
  output logic             full,
  output logic             cmd_push,
  output logic [CMD_W-1:0] cmd_data,
  input  logic             cmd_full
);

  localparam int SW = idx_w(SLOTS);
  localparam int OW = $clog2(LINE_BYTES);
  localparam int TW = tmo_w(SLOTS);
  localparam logic [TW-1:0] RELOAD   = TW'(4 * SLOTS + 3);
  localparam logic [OW-1:0] WRAP_TOP = OW'(LINE_BYTES - 4);

  typedef struct packed {
    logic          is_line;
    logic [SW-1:0] slot;
    logic [OW-1:0] pos;
    logic [7:0]    value;
  } cmd_t;

  logic [7:0]    owner [SLOTS];
  logic [TW-1:0] tmo   [SLOTS];
  logic [OW-1:0] offs  [SLOTS];
  logic [SW-1:0] frame_slot;
  logic          frame_active;

  logic          accept;
  logic          mfound;
  logic          ifound;
  logic [SW-1:0] mpick;
  logic [SW-1:0] ipick;
  logic [SW-1:0] pick;
  logic          has_pick;
  logic          cur_act;
  logic [SW-1:0] cur_slot;
  logic [OW-1:0] cur_off;
  logic [7:0]    cur_owner;
  logic          is_term;
  logic          do_byte;
  logic          act_next;
  logic [OW-1:0] off_next;
  cmd_t          cmd;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // last busy slot of this channel with a partial line, else first idle slot
  always_comb begin
    mfound = 1'b0;
    mpick  = '0;
    ifound = 1'b0;
    ipick  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tmo[i] != '0 && owner[i] == channel && offs[i] != '0) begin
        mfound = 1'b1;
        mpick  = SW'(i);
      end
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tmo[i] == '0) begin
        ifound = 1'b1;
        ipick  = SW'(i);
      end
    end
  end

  assign pick      = mfound ? mpick : ipick;
  assign has_pick  = mfound || ifound;
  assign cur_act   = frame_start ? has_pick : frame_active;
  assign cur_slot  = frame_start ? pick : frame_slot;
  assign cur_off   = offs[cur_slot];
  assign cur_owner = frame_start ? channel : owner[cur_slot];
  assign is_term   = (data == CHAR_CR) || (data == CHAR_LF);
  assign do_byte   = cur_act && byte_present && (data != CHAR_NUL);
  assign act_next  = cur_act && !(byte_present && ((data == CHAR_NUL) || is_term));
  assign off_next  = is_term ? '0 : ((cur_off == WRAP_TOP) ? '0 : cur_off + 1'b1);

  always_comb begin
    cmd.is_line = is_term;
    cmd.slot    = cur_slot;
    cmd.pos     = cur_off;
    cmd.value   = is_term ? cur_owner : data;
  end

  assign cmd_push = accept && do_byte;
  assign cmd_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        owner[i] <= '0;
        tmo[i]   <= '0;
        offs[i]  <= '0;
      end
      frame_slot   <= '0;
      frame_active <= 1'b0;
    end else if (accept) begin
      if (frame_start) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (has_pick && pick == SW'(i)) begin
            tmo[i] <= RELOAD;
          end else if (tmo[i] != '0) begin
            tmo[i] <= tmo[i] - 1'b1;
          end
        end
        if (has_pick) begin
          owner[pick] <= channel;
          frame_slot  <= pick;
        end
      end
      if (do_byte) begin
        offs[cur_slot] <= off_next;
      end
      frame_active <= act_next;
    end
  end

endmodule

>>> hw/rtl/mla_back.sv
// mla_back: line memory, command execution and line readout into the result queue
// depends on mla_pkg and mla_fifo
`timescale 1ns / 1ps

module mla_back
  import mla_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int LINE_BYTES = DEF_LINE_BYTES,
  parameter int CMD_W      = 1 + idx_w(SLOTS) + $clog2(LINE_BYTES) + 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CMD_W-1:0] cmd_data,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  output out_t             res,
  output logic             res_empty,
  input  logic             res_pop
);

  localparam int SW    = idx_w(SLOTS);
  localparam int OW    = $clog2(LINE_BYTES);
  localparam int DEPTH = SLOTS * LINE_BYTES;
  localparam int AW    = idx_w(DEPTH);
  localparam int OCW   = cnt_w(OUT_QDEPTH);
  localparam logic [AW-1:0] LB_A = AW'(LINE_BYTES);

  typedef struct packed {
    logic          is_line;
    logic [SW-1:0] slot;
    logic [OW-1:0] pos;
    logic [7:0]    value;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LF,
    B_EMIT
  } bstate_t;

  bstate_t       state;
  cmd_t          in_cmd;
  cmd_t          cur;
  logic [OW-1:0] k;
  logic [OW-1:0] k_end;

  logic [7:0]    mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic          rd_pend;
  logic          rd_last;
  logic [1:0]    rd_slot;
  logic [7:0]    rd_owner;
  logic [SW+1:0] slot_ext;

  logic          res_full;
  logic [OCW-1:0] res_count;
  logic          space;
  out_t          res_in;

  assign in_cmd   = cmd_data;
  assign cmd_pop  = (state == B_IDLE) && !cmd_empty;
  assign k_end    = cur.pos + 1'b1;
  assign slot_ext = {2'b00, cur.slot};
  assign space    = ({1'b0, res_count} + (OCW + 1)'(rd_pend)) < (OCW + 1)'(OUT_QDEPTH);

  always_comb begin
    we    = 1'b0;
    waddr = AW'(in_cmd.slot) * LB_A + AW'(in_cmd.pos);
    wdata = in_cmd.is_line ? CHAR_CR : in_cmd.value;
    unique case (state)
      B_IDLE: begin
        we = !cmd_empty;
      end
      B_LF: begin
        we    = 1'b1;
        waddr = AW'(cur.slot) * LB_A + AW'(cur.pos) + AW'(1);
        wdata = CHAR_LF;
      end
      B_EMIT: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign re    = (state == B_EMIT) && space;
  assign raddr = AW'(cur.slot) * LB_A + AW'(k);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_last  <= (k == k_end);
      rd_slot  <= slot_ext[1:0];
      rd_owner <= cur.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      rd_pend <= 1'b0;
      k       <= '0;
    end else begin
      rd_pend <= re;
      unique case (state)
        B_IDLE: begin
          if (!cmd_empty && in_cmd.is_line) begin
            cur   <= in_cmd;
            state <= B_LF;
          end
        end
        B_LF: begin
          k     <= '0;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (space) begin
            if (k == k_end) begin
              state <= B_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_in.line_byte    = rdata;
    res_in.slot_index   = rd_slot;
    res_in.line_channel = rd_owner;
    res_in.last         = rd_last;
  end

  mla_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rd_pend),
    .din   (res_in),
    .pop   (res_pop),
    .dout  (res),
    .full  (res_full),
    .empty (res_empty),
    .count (res_count)
  );

  // space accounting keeps the queue from overflowing; full is never seen high on a push
  logic unused_full;
  assign unused_full = res_full;

endmodule

>>> hw/rtl/multichannel_line_assembler.sv
// multichannel_line_assembler: top level, front end, command queue and back end
// depends on mla_pkg, mla_fifo, mla_front, mla_back
`timescale 1ns / 1ps

// Bytes of framed, channel-tagged traffic come in on a push/full queue port and
// completed lines (stored bytes, then CR, LF) leave on an empty/pop queue port,
// one byte per beat, last set on the LF. The front end takes one beat per cycle:
// on a frame start it ages the other busy slots and binds the frame to a slot in
// that same cycle. Each data byte or line end becomes one command in a 4-entry
// queue. The back end writes each stored byte; for a line end it writes CR, then
// LF, then reads the line memory once per byte of the line, CR and LF included,
// holding while the result queue has no space; input stalls only while the
// command queue is full. No clearing pass runs after reset.
module multichannel_line_assembler
  import mla_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] channel,
  input  logic [7:0] data,
  input  logic       frame_start,
  input  logic       byte_present,
  input  logic       push,
  output logic       full,
  output logic [7:0] line_byte,
  output logic [1:0] slot_index,
  output logic [7:0] line_channel,
  output logic       last,
  output logic       empty,
  input  logic       pop
);

  localparam int CMD_W = 1 + idx_w(SLOTS) + $clog2(LINE_BYTES) + 8;

  logic                        cmd_push;
  logic [CMD_W-1:0]            cmd_in;
  logic [CMD_W-1:0]            cmd_out;
  logic                        cmd_full;
  logic                        cmd_empty;
  logic                        cmd_pop;
  logic [cnt_w(CMD_QDEPTH)-1:0] cmd_count;
  out_t                        res;

  mla_front #(
    .SLOTS      (SLOTS),
    .LINE_BYTES (LINE_BYTES),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .channel      (channel),
    .data         (data),
    .frame_start  (frame_start),
    .byte_present (byte_present),
    .push         (push),
    .full         (full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in),
    .cmd_full     (cmd_full)
  );

  mla_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  mla_back #(
    .SLOTS      (SLOTS),
    .LINE_BYTES (LINE_BYTES),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign line_byte    = res.line_byte;
  assign slot_index   = res.slot_index;
  assign line_channel = res.line_channel;
  assign last         = res.last;

  // queue depth is not needed here
  logic unused_count;
  assign unused_count = ^cmd_count;

endmodule
